>>> rtl/core/cius_pkg.sv
package cius_pkg;

  localparam int unsigned HDR_LEN   = 13;
  localparam int unsigned STORE_LEN = HDR_LEN - 1;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned ADDR_W    = 3;

  localparam logic [7:0] MAGIC_0         = 8'h52;
  localparam logic [7:0] MAGIC_1         = 8'h54;
  localparam logic [7:0] MAGIC_2         = 8'h34;
  localparam logic [7:0] MAGIC_3         = 8'h4F;
  localparam logic [7:0] FORMAT_VERSION  = 8'd1;

  localparam logic [ADDR_W-3:0] REG_EXPECTED_TOTAL = '0;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_FS,
    PH_FW
  } phase_t;

  typedef enum logic [1:0] {
    DEST_HEADER  = 2'd0,
    DEST_FS      = 2'd1,
    DEST_FW      = 2'd2,
    DEST_DISCARD = 2'd3
  } dest_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_HEADER_OK = 3'd1,
    EV_FS_DONE   = 3'd2,
    EV_DONE      = 3'd3,
    EV_BAD_MAGIC = 3'd4,
    EV_MISMATCH  = 3'd5,
    EV_TOO_SMALL = 3'd6
  } event_t;

  typedef logic [STORE_LEN-1:0][7:0] hdr_store_t;

  typedef struct packed {
    phase_t             phase;
    logic [CNT_W-1:0]   header_count;
    logic [31:0]        fs_len;
    logic [31:0]        fw_len;
    logic [31:0]        seg_cnt;
    logic [31:0]        byte_cnt;
  } split_state_t;

  typedef struct packed {
    logic [7:0]  data_out;
    dest_t       destination;
    logic [31:0] segment_offset;
    event_t      event_res;
    logic [31:0] announced_length;
  } split_result_t;

  typedef struct packed {
    logic             wr;
    logic [CNT_W-1:0] idx;
  } hdr_write_t;

endpackage

>>> rtl/core/combined_image_upload_splitter_core.sv
// Each accepted input beat's result beat is registered and appears in the cycle after acceptance.
// Throughput: one byte per cycle; the state update and the header checks
// (one 34-bit add and compare) finish in the cycle the beat is accepted.
// A waiting result does not stop the next beat while result_ready is high.
// Reset is synchronous: phase idle, counters, lengths and expected_total zero,
// no result pending; header bytes are undefined until written.
module combined_image_upload_splitter_core import cius_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              byte_valid,
  output logic              byte_ready,
  input  logic [7:0]        data_byte,
  input  logic              first_byte,
  output logic              result_valid,
  input  logic              result_ready,
  output logic [7:0]        data_out,
  output logic [1:0]        destination,
  output logic [31:0]       segment_offset,
  output logic [2:0]        event_res,
  output logic [31:0]       announced_length
);

  logic [31:0]   expected_total;
  split_state_t  state;
  split_state_t  state_next;
  split_result_t res_next;
  split_result_t res;
  hdr_write_t    hdr_wr;
  hdr_store_t    hdr;
  logic          accept;

  cius_cfg u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .expected_total (expected_total)
  );

  cius_step u_step (
    .cur            (state),
    .hdr            (hdr),
    .expected_total (expected_total),
    .data_byte      (data_byte),
    .first_byte     (first_byte),
    .nxt            (state_next),
    .res            (res_next),
    .hdr_wr         (hdr_wr)
  );

  assign byte_ready = !result_valid || result_ready;
  assign accept     = byte_valid && byte_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= '{phase: PH_IDLE, default: '0};
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        state        <= state_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hdr_wr.wr) begin
      hdr[hdr_wr.idx] <= data_byte;
    end
  end

  assign data_out         = res.data_out;
  assign destination      = res.destination;
  assign segment_offset   = res.segment_offset;
  assign event_res        = res.event_res;
  assign announced_length = res.announced_length;

endmodule

>>> rtl/core/cius_cfg.sv
module cius_cfg import cius_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [31:0]       expected_total
);

  logic sel_total;

  assign sel_total = (paddr[ADDR_W-1:2] == REG_EXPECTED_TOTAL);
  assign pready    = 1'b1;
  assign prdata    = sel_total ? expected_total : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_total <= 32'd0;
    end else if (psel && penable && pwrite && pready && sel_total) begin
      expected_total <= pwdata;
    end
  end

endmodule

>>> rtl/core/cius_step.sv
module cius_step import cius_pkg::*; (
  input  split_state_t  cur,
  input  hdr_store_t    hdr,
  input  logic [31:0]   expected_total,
  input  logic [7:0]    data_byte,
  input  logic          first_byte,
  output split_state_t  nxt,
  output split_result_t res,
  output hdr_write_t    hdr_wr
);

  split_state_t st;
  logic         magic_ok;
  logic [31:0]  fs_len;
  logic [31:0]  fw_len;
  logic [33:0]  sum;
  logic [31:0]  seg_inc;
  logic [32:0]  bc_inc;

  always_comb begin
    st = cur;
    if (first_byte) begin
      st.phase        = (expected_total <= 32'(HDR_LEN)) ? PH_IDLE : PH_HEADER;
      st.header_count = '0;
      st.fs_len       = 32'd0;
      st.fw_len       = 32'd0;
      st.seg_cnt      = 32'd0;
      st.byte_cnt     = 32'd0;
    end
  end

  assign magic_ok = (hdr[0] == MAGIC_0) && (hdr[1] == MAGIC_1) && (hdr[2] == MAGIC_2)
                 && (hdr[3] == MAGIC_3) && (hdr[4] == FORMAT_VERSION);
  assign fs_len   = {hdr[8], hdr[7], hdr[6], hdr[5]};
  assign fw_len   = {data_byte, hdr[11], hdr[10], hdr[9]};
  assign sum      = 34'(HDR_LEN) + {2'b00, fs_len} + {2'b00, fw_len};
  assign seg_inc  = st.seg_cnt + 32'd1;
  assign bc_inc   = {1'b0, st.byte_cnt} + 33'd1;

  always_comb begin
    nxt                  = st;
    nxt.byte_cnt         = bc_inc[31:0];
    res.data_out         = data_byte;
    res.destination      = DEST_DISCARD;
    res.segment_offset   = 32'd0;
    res.event_res        = (first_byte && st.phase == PH_IDLE) ? EV_TOO_SMALL : EV_NONE;
    res.announced_length = 32'd0;
    hdr_wr.wr            = 1'b0;
    hdr_wr.idx           = st.header_count;
    unique case (st.phase)
      PH_HEADER: begin
        res.destination    = DEST_HEADER;
        res.segment_offset = 32'(st.header_count);
        nxt.header_count   = st.header_count + CNT_W'(1);
        hdr_wr.wr          = (st.header_count != CNT_W'(STORE_LEN));
        if (st.header_count == CNT_W'(STORE_LEN)) begin
          nxt.fs_len = fs_len;
          nxt.fw_len = fw_len;
          if (!magic_ok) begin
            res.event_res = EV_BAD_MAGIC;
            nxt.phase     = PH_IDLE;
          end else if (fs_len == 32'd0 || fw_len == 32'd0
                       || sum != {2'b00, expected_total}) begin
            res.event_res = EV_MISMATCH;
            nxt.phase     = PH_IDLE;
          end else begin
            res.event_res        = EV_HEADER_OK;
            res.announced_length = fs_len;
            nxt.seg_cnt          = 32'd0;
            nxt.phase            = PH_FS;
          end
        end
      end
      PH_FS: begin
        res.destination    = DEST_FS;
        res.segment_offset = st.seg_cnt;
        nxt.seg_cnt        = seg_inc;
        if (seg_inc >= st.fs_len) begin
          res.event_res        = EV_FS_DONE;
          res.announced_length = st.fw_len;
          nxt.seg_cnt          = 32'd0;
          nxt.phase            = PH_FW;
        end
      end
      PH_FW: begin
        res.destination    = DEST_FW;
        res.segment_offset = st.seg_cnt;
        nxt.seg_cnt        = seg_inc;
        if (bc_inc >= {1'b0, expected_total}) begin
          res.event_res = EV_DONE;
          nxt.phase     = PH_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> verif/tb_combined_image_upload_splitter_core.sv
`timescale 1ns / 1ps

module tb_combined_image_upload_splitter_core import cius_pkg::*; ();

  localparam int CYCLE_LIMIT = 1000000;
  localparam int BEAT_TARGET = 1150;

  typedef struct {
    logic [7:0] data;
    logic       first;
  } upload_beat_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              byte_valid = 1'b0;
  logic              byte_ready;
  logic [7:0]        data_byte = '0;
  logic              first_byte = 1'b0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  logic [7:0]        data_out;
  logic [1:0]        destination;
  logic [31:0]       segment_offset;
  logic [2:0]        event_res;
  logic [31:0]       announced_length;

  combined_image_upload_splitter_core dut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .byte_valid       (byte_valid),
    .byte_ready       (byte_ready),
    .data_byte        (data_byte),
    .first_byte       (first_byte),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .data_out         (data_out),
    .destination      (destination),
    .segment_offset   (segment_offset),
    .event_res        (event_res),
    .announced_length (announced_length)
  );

  always #10 clk = ~clk;

  phase_t        split_phase = PH_IDLE;
  logic [7:0]    hdr_bytes [HDR_LEN];
  int unsigned   hdr_fill = 0;
  logic [31:0]   fs_len = '0;
  logic [31:0]   fw_len = '0;
  logic [31:0]   seg_pos = '0;
  logic [31:0]   body_pos = '0;
  logic [31:0]   total_cfg = '0;

  upload_beat_t  pending_beats[$];
  split_result_t expected_results[$];

  int errors = 0;
  int cycles = 0;
  int beats_queued = 0;
  int beats_sent = 0;
  int cfg_writes = 0;
  int uploads_done = 0;
  int rejects = 0;
  int tx_gap = 0;
  int tx_steady = 0;
  int rx_hold = 0;
  int rx_steady = 0;
  int rx_beats = 0;
  logic long_hold_done = 1'b0;

  task automatic predict_split(input logic [7:0] b, input logic first);
    split_result_t r;
    logic [33:0]   sum;
    int unsigned   pos;
    r.data_out = b;
    r.destination = DEST_DISCARD;
    r.segment_offset = '0;
    r.event_res = EV_NONE;
    r.announced_length = '0;
    if (first) begin
      split_phase = PH_IDLE;
      hdr_fill = 0;
      fs_len = '0;
      fw_len = '0;
      seg_pos = '0;
      body_pos = '0;
      if (total_cfg <= HDR_LEN) begin
        r.event_res = EV_TOO_SMALL;
      end else begin
        split_phase = PH_HEADER;
      end
    end
    case (split_phase)
      PH_HEADER: begin
        pos = (hdr_fill >= HDR_LEN) ? HDR_LEN - 1 : hdr_fill;
        hdr_bytes[pos] = b;
        r.destination = DEST_HEADER;
        r.segment_offset = pos;
        hdr_fill = pos + 1;
        if (hdr_fill == HDR_LEN) begin
          if (hdr_bytes[0] != MAGIC_0 || hdr_bytes[1] != MAGIC_1 ||
              hdr_bytes[2] != MAGIC_2 || hdr_bytes[3] != MAGIC_3 ||
              hdr_bytes[4] != FORMAT_VERSION) begin
            r.event_res = EV_BAD_MAGIC;
            split_phase = PH_IDLE;
          end else begin
            fs_len = {hdr_bytes[8], hdr_bytes[7], hdr_bytes[6], hdr_bytes[5]};
            fw_len = {hdr_bytes[12], hdr_bytes[11], hdr_bytes[10], hdr_bytes[9]};
            sum = 34'(HDR_LEN) + 34'(fs_len) + 34'(fw_len);
            if (fs_len == 0 || fw_len == 0 || sum != 34'(total_cfg)) begin
              r.event_res = EV_MISMATCH;
              split_phase = PH_IDLE;
            end else begin
              r.event_res = EV_HEADER_OK;
              r.announced_length = fs_len;
              seg_pos = '0;
              split_phase = PH_FS;
            end
          end
        end
      end
      PH_FS: begin
        r.destination = DEST_FS;
        r.segment_offset = seg_pos;
        seg_pos = seg_pos + 1;
        if (seg_pos >= fs_len) begin
          r.event_res = EV_FS_DONE;
          r.announced_length = fw_len;
          seg_pos = '0;
          split_phase = PH_FW;
        end
      end
      PH_FW: begin
        r.destination = DEST_FW;
        r.segment_offset = seg_pos;
        seg_pos = seg_pos + 1;
        if (33'(body_pos) + 33'd1 >= 33'(total_cfg)) begin
          r.event_res = EV_DONE;
          split_phase = PH_IDLE;
        end
      end
      default: ;
    endcase
    body_pos = body_pos + 1;
    expected_results.push_back(r);
  endtask

  function automatic int tx_idle_len();
    int unsigned r;
    if (tx_steady > 0) begin
      tx_steady--;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 15) tx_steady = $urandom_range(40, 150);
    if (r < 600) return 0;
    if (r < 950) return $urandom_range(1, 3);
    return $urandom_range(12, 60);
  endfunction

  always @(posedge clk) begin : tx_drive
    upload_beat_t nxt;
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      if (byte_valid && byte_ready) begin
        predict_split(data_byte, first_byte);
        beats_sent++;
      end
      if (!byte_valid || byte_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          byte_valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          nxt = pending_beats.pop_front();
          byte_valid <= 1'b1;
          data_byte <= nxt.data;
          first_byte <= nxt.first;
          tx_gap = tx_idle_len();
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : rx_check
    split_result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual data %0h dest %0d",
                 $time, data_out, destination);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("data_out", 32'(want.data_out), 32'(data_out));
        check_field("destination", 32'(want.destination), 32'(destination));
        check_field("segment_offset", want.segment_offset, segment_offset);
        check_field("event_res", 32'(want.event_res), 32'(event_res));
        check_field("announced_length", want.announced_length, announced_length);
        if (want.event_res == EV_DONE) uploads_done++;
        if (want.event_res == EV_BAD_MAGIC || want.event_res == EV_MISMATCH ||
            want.event_res == EV_TOO_SMALL) rejects++;
      end
    end
  end

  always @(posedge clk) begin : rx_pace
    int unsigned r;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) rx_beats++;
      if (rx_hold > 0) begin
        rx_hold--;
        result_ready <= 1'b0;
      end else if (!long_hold_done && rx_beats >= 300 && pending_beats.size() >= 8) begin
        // hold off long enough to back up the input side
        long_hold_done = 1'b1;
        rx_hold = 400;
        result_ready <= 1'b0;
      end else if (rx_steady > 0) begin
        rx_steady--;
        result_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 999);
        if (r < 15) rx_steady = $urandom_range(40, 150);
        if (r < 650) begin
          result_ready <= 1'b1;
        end else begin
          result_ready <= 1'b0;
          rx_hold = (r < 960) ? $urandom_range(0, 3) : $urandom_range(12, 60);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
      $display("combined_image_upload_splitter_core regression: fail");
      $finish;
    end
  end

  task automatic push_beat(input logic [7:0] d, input logic f);
    upload_beat_t ub;
    ub.data = d;
    ub.first = f;
    pending_beats.push_back(ub);
    beats_queued++;
  endtask

  task automatic push_body(input int unsigned n);
    repeat (n) push_beat(8'($urandom), 1'b0);
  endtask

  task automatic push_header(input logic [31:0] fs, input logic [31:0] fw,
                             input int bad_idx, input logic [7:0] flip,
                             input int unsigned n);
    logic [7:0] h [HDR_LEN];
    h[0] = MAGIC_0;
    h[1] = MAGIC_1;
    h[2] = MAGIC_2;
    h[3] = MAGIC_3;
    h[4] = FORMAT_VERSION;
    for (int i = 0; i < 4; i++) begin
      h[5 + i] = fs[8*i +: 8];
      h[9 + i] = fw[8*i +: 8];
    end
    if (bad_idx >= 0) h[bad_idx] = h[bad_idx] ^ flip;
    for (int i = 0; i < n; i++) push_beat(h[i], i == 0);
  endtask

  task automatic settle();
    @(negedge clk);
    while (pending_beats.size() != 0 || byte_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_total(input logic [31:0] v);
    settle();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_EXPECTED_TOTAL, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    total_cfg = v;
    cfg_writes++;
  endtask

  initial begin : stim
    int unsigned body, fs, fw, c, nt, k, r;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // total at its reset value: discard in idle, start rejected as too small
    push_beat(8'h00, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(8'hA5, 1'b1);
    write_total(32'd0);
    push_beat(8'h81, 1'b1);
    write_total(32'd13);
    push_beat(8'h5A, 1'b1);
    push_beat(8'h00, 1'b0);

    write_total(32'd15);
    push_header(32'd1, 32'd1, -1, 8'h00, HDR_LEN);
    push_body(2);
    push_beat(8'hFF, 1'b0);
    push_header(32'd1, 32'd1, 3, 8'h1F, HDR_LEN);
    push_header(32'd1, 32'd1, 4, 8'h01, HDR_LEN);
    push_header(32'd1, 32'd1, 4, 8'hFE, HDR_LEN);
    push_header(32'd0, 32'd2, -1, 8'h00, HDR_LEN);
    push_header(32'd2, 32'd0, -1, 8'h00, HDR_LEN);
    push_header(32'd1, 32'd2, -1, 8'h00, HDR_LEN);
    push_header(32'd1, 32'd1, -1, 8'h00, 3);
    push_header(32'd1, 32'd1, -1, 8'h00, HDR_LEN);
    push_body(2);

    write_total(32'hFFFF_FFFF);
    push_header(32'hFFFF_FFFF, 32'hFFFF_FFFF, -1, 8'h00, HDR_LEN);
    push_header(32'hFFFF_FFFF, 32'hFFFF_FFF3, -1, 8'h00, HDR_LEN);
    push_header(32'h8000_0000, 32'h7FFF_FFF2, -1, 8'h00, HDR_LEN);
    push_body(3);
    push_header(32'd1, 32'hFFFF_FFF1, -1, 8'h00, HDR_LEN);
    push_body(2);

    // raise, then lower, the total while in the firmware segment
    write_total(32'd30);
    push_header(32'd5, 32'd12, -1, 8'h00, HDR_LEN);
    push_body(8);
    write_total(32'd40);
    push_body(19);
    write_total(32'd30);
    push_header(32'd5, 32'd12, -1, 8'h00, HDR_LEN);
    push_body(8);
    write_total(32'd20);
    push_body(1);
    push_beat(8'h3C, 1'b0);

    while (beats_queued < BEAT_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        write_total($urandom_range(0, HDR_LEN));
        repeat ($urandom_range(1, 4)) push_beat(8'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        body = (r < 12) ? $urandom_range(40, 300) : $urandom_range(2, 40);
        write_total(HDR_LEN + body);
        repeat ($urandom_range(3, 6)) begin
          fs = $urandom_range(1, body - 1);
          fw = body - fs;
          k = $urandom_range(0, 99);
          if (k < 62) begin
            push_header(fs, fw, -1, 8'h00, HDR_LEN);
            push_body(body);
          end else if (k < 68) begin
            push_header(fs, fw, -1, 8'h00, HDR_LEN);
            push_body($urandom_range(0, body - 1));
          end else if (k < 72) begin
            push_header(fs, fw, -1, 8'h00, $urandom_range(1, HDR_LEN - 1));
          end else if (k < 78) begin
            push_header(fs, fw, $urandom_range(0, 4), 8'($urandom_range(1, 255)), HDR_LEN);
            push_body($urandom_range(0, 3));
          end else if (k < 86) begin
            case ($urandom_range(0, 3))
              0: push_header(32'd0, body, -1, 8'h00, HDR_LEN);
              1: push_header(body, 32'd0, -1, 8'h00, HDR_LEN);
              2: push_header(fs, fw + $urandom_range(1, 3), -1, 8'h00, HDR_LEN);
              default: push_header(fs + 32'h8000_0000, fw + 32'h8000_0000, -1, 8'h00,
                                   HDR_LEN);
            endcase
            push_body($urandom_range(0, 3));
          end else if (k < 93 && fw >= 2) begin
            push_header(fs, fw, -1, 8'h00, HDR_LEN);
            c = $urandom_range(fs + 1, body - 1);
            push_body(c);
            nt = HDR_LEN + c + $urandom_range(0, 40);
            write_total(nt);
            push_body((nt > HDR_LEN + c) ? nt - HDR_LEN - c : 1);
            write_total(HDR_LEN + body);
          end else begin
            repeat ($urandom_range(1, 6)) push_beat(8'($urandom), 1'b0);
          end
        end
      end
    end

    settle();
    repeat (4) @(posedge clk);
    $display("Sent %0d byte beats over %0d total settings; %0d uploads completed,",
             beats_sent, cfg_writes, uploads_done);
    $display("%0d starts rejected, long output stall %0s.", rejects,
             long_hold_done ? "applied" : "not reached");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("combined_image_upload_splitter_core regression: pass");
    end else begin
      $display("combined_image_upload_splitter_core regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/cius_pkg.sv
rtl/core/cius_cfg.sv
rtl/core/cius_step.sv
rtl/core/combined_image_upload_splitter_core.sv
verif/tb_combined_image_upload_splitter_core.sv
